// ===== rtl/core/v3a_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_pkg
// Opcodes, lane result type and saturation helper for the vector ALU.
// ----------------------------------------------------------------------------
package v3a_pkg;

  localparam int DIV_BITS = 48;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_DOT   = 3'd4;
  localparam logic [2:0] OP_CROSS = 3'd5;

  localparam logic signed [49:0] Q_MAX = 50'sd2147483647;
  localparam logic signed [49:0] Q_MIN = -50'sd2147483648;

  typedef struct packed {
    logic signed [47:0] p0;
    logic signed [47:0] p1;
    logic signed [32:0] sum;
    logic [47:0]        quo;
    logic               quo_neg;
    logic               div_zero;
  } v3a_lane_t;

  // {overflow flag, clamped value}
  function automatic logic [32:0] sat32(input logic signed [49:0] v);
    logic [32:0] r;
    if (v > Q_MAX) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < Q_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/v3a_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_lane
// One component lane: two multipliers, add/sub, and a pipelined restoring
// divider, one quotient bit per stage, with the other results delayed to match.
// ----------------------------------------------------------------------------
module v3a_lane import v3a_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic signed [31:0] m0a,
  input  logic signed [31:0] m0b,
  input  logic signed [31:0] m1a,
  input  logic signed [31:0] m1b,
  output v3a_lane_t          res
);

  logic [2:0]         op_q;
  logic signed [31:0] a_q, b_q, m0a_q, m0b_q, m1a_q, m1b_q;

  logic signed [63:0] prod0, prod1;
  logic signed [32:0] sum0;

  logic signed [47:0] p0_d  [1:DIV_BITS];
  logic signed [47:0] p1_d  [1:DIV_BITS];
  logic signed [32:0] sum_d [1:DIV_BITS];

  logic [31:0] rem_q [1:DIV_BITS];
  logic [47:0] nq_q  [1:DIV_BITS];
  logic [31:0] dv_q  [1:DIV_BITS];
  logic        neg_q [1:DIV_BITS];
  logic        dz_q  [1:DIV_BITS];

  logic [31:0] rem_next [1:DIV_BITS];
  logic [47:0] nq_next  [1:DIV_BITS];
  logic [31:0] dv_next  [1:DIV_BITS];
  logic        neg_next [1:DIV_BITS];
  logic        dz_next  [1:DIV_BITS];

  logic [31:0] a_mag, b_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      op_q  <= opcode;
      a_q   <= a;
      b_q   <= b;
      m0a_q <= m0a;
      m0b_q <= m0b;
      m1a_q <= m1a;
      m1b_q <= m1b;
    end
  end

  assign prod0 = 64'(m0a_q) * 64'(m0b_q);
  assign prod1 = 64'(m1a_q) * 64'(m1b_q);
  assign sum0  = (op_q == OP_SUB) ? ({a_q[31], a_q} - {b_q[31], b_q})
                                  : ({a_q[31], a_q} + {b_q[31], b_q});

  assign a_mag = a_q[31] ? (~a_q + 32'd1) : a_q;
  assign b_mag = b_q[31] ? (~b_q + 32'd1) : b_q;

  always_comb begin
    logic [31:0] r_s;
    logic [47:0] n_s;
    logic [31:0] d_s;
    logic [32:0] t;
    for (int k = 1; k <= DIV_BITS; k++) begin
      if (k == 1) begin
        r_s         = '0;
        n_s         = {a_mag, 16'h0000};
        d_s         = b_mag;
        neg_next[k] = a_q[31] ^ b_q[31];
        dz_next[k]  = (b_q == 32'sd0);
      end else begin
        r_s         = rem_q[k-1];
        n_s         = nq_q[k-1];
        d_s         = dv_q[k-1];
        neg_next[k] = neg_q[k-1];
        dz_next[k]  = dz_q[k-1];
      end
      t          = {r_s, n_s[47]};
      dv_next[k] = d_s;
      if (t >= {1'b0, d_s}) begin
        rem_next[k] = 32'(t - {1'b0, d_s});
        nq_next[k]  = {n_s[46:0], 1'b1};
      end else begin
        rem_next[k] = t[31:0];
        nq_next[k]  = {n_s[46:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_d[1]  <= prod0[63:16];
      p1_d[1]  <= prod1[63:16];
      sum_d[1] <= sum0;
      for (int k = 2; k <= DIV_BITS; k++) begin
        p0_d[k]  <= p0_d[k-1];
        p1_d[k]  <= p1_d[k-1];
        sum_d[k] <= sum_d[k-1];
      end
      for (int k = 1; k <= DIV_BITS; k++) begin
        rem_q[k] <= rem_next[k];
        nq_q[k]  <= nq_next[k];
        dv_q[k]  <= dv_next[k];
        neg_q[k] <= neg_next[k];
        dz_q[k]  <= dz_next[k];
      end
    end
  end

  assign res.p0       = p0_d[DIV_BITS];
  assign res.p1       = p1_d[DIV_BITS];
  assign res.sum      = sum_d[DIV_BITS];
  assign res.quo      = nq_q[DIV_BITS];
  assign res.quo_neg  = neg_q[DIV_BITS];
  assign res.div_zero = dz_q[DIV_BITS];

endmodule

// ===== rtl/core/v3a_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3a_merge
// Combines the three lane results per opcode, saturates, registers the output.
// ----------------------------------------------------------------------------
module v3a_merge import v3a_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [2:0]         opcode,
  input  logic               last,
  input  v3a_lane_t          lane [3],
  output logic signed [31:0] r_x,
  output logic signed [31:0] r_y,
  output logic signed [31:0] r_z,
  output logic               saturated,
  output logic               divide_by_zero,
  output logic               last_out
);

  logic signed [49:0] val [3];
  logic               dzc [3];
  logic [31:0]        res [3];
  logic               sat_any, dz_any;

  always_comb begin
    logic [32:0] c;
    sat_any = 1'b0;
    dz_any  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      val[i] = '0;
      dzc[i] = 1'b0;
    end
    case (opcode)
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) val[i] = 50'(lane[i].sum);
      end
      OP_MUL: begin
        for (int i = 0; i < 3; i++) val[i] = 50'(lane[i].p0);
      end
      OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          dzc[i] = lane[i].div_zero;
          val[i] = lane[i].quo_neg ? -{2'b00, lane[i].quo} : {2'b00, lane[i].quo};
        end
      end
      OP_DOT: begin
        val[0] = 50'(lane[0].p0) + 50'(lane[1].p0) + 50'(lane[2].p0);
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) val[i] = 50'(lane[i].p0) - 50'(lane[i].p1);
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      c = sat32(val[i]);
      if (dzc[i]) begin
        res[i] = 32'h7FFF_FFFF;
        dz_any = 1'b1;
      end else begin
        res[i]  = c[31:0];
        sat_any = sat_any | c[32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_x            <= res[0];
      r_y            <= res[1];
      r_z            <= res[2];
      saturated      <= sat_any;
      divide_by_zero <= dz_any;
      last_out       <= last;
    end
  end

endmodule

// ===== rtl/core/vector3_arith_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_arith_unit
// Q16.16 three-component vector ALU: add, sub, mul, div, dot, cross.
// ----------------------------------------------------------------------------
// Takes one request per clock while not stalled and returns one result per
// request, in order. Every request passes through the 48-stage restoring
// divider in each of the three component lanes; all opcodes share that one
// pipeline. The whole pipeline holds while out_stall is high with a result
// waiting, and in_stall follows it.
module vector3_arith_unit import v3a_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] r_x,
  output logic signed [31:0] r_y,
  output logic signed [31:0] r_z,
  output logic               saturated,
  output logic               divide_by_zero,
  output logic               last_out
);

  logic              en;
  logic              vld    [0:DIV_BITS];
  logic [2:0]        op_d   [0:DIV_BITS];
  logic              last_d [0:DIV_BITS];
  logic signed [31:0] av [3];
  logic signed [31:0] bv [3];
  logic              is_cross;
  v3a_lane_t         lane_res [3];

  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;
  assign is_cross = (opcode == OP_CROSS);

  assign av[0] = a_x;
  assign av[1] = a_y;
  assign av[2] = a_z;
  assign bv[0] = b_x;
  assign bv[1] = b_y;
  assign bv[2] = b_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_BITS; k++) vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k <= DIV_BITS; k++) vld[k] <= vld[k-1];
      out_valid <= vld[DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_d[0]   <= opcode;
      last_d[0] <= last_in;
      for (int k = 1; k <= DIV_BITS; k++) begin
        op_d[k]   <= op_d[k-1];
        last_d[k] <= last_d[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3a_lane u_lane (
      .clk    (clk),
      .en     (en),
      .opcode (opcode),
      .a      (av[i]),
      .b      (bv[i]),
      .m0a    (is_cross ? av[(i + 1) % 3] : av[i]),
      .m0b    (is_cross ? bv[(i + 2) % 3] : bv[i]),
      .m1a    (av[(i + 2) % 3]),
      .m1b    (bv[(i + 1) % 3]),
      .res    (lane_res[i])
    );
  end

  v3a_merge u_merge (
    .clk            (clk),
    .en             (en),
    .opcode         (op_d[DIV_BITS]),
    .last           (last_d[DIV_BITS]),
    .lane           (lane_res),
    .r_x            (r_x),
    .r_y            (r_y),
    .r_z            (r_z),
    .saturated      (saturated),
    .divide_by_zero (divide_by_zero),
    .last_out       (last_out)
  );

endmodule
